/* hdl/msl_pkg.sv */
`default_nettype none
package msl_pkg;

  localparam int unsigned NumChannelsDef   = 32;
  localparam int unsigned AngleFracBitsDef = 12;
  localparam int unsigned MaxOut           = 32;

  // one table entry of the channel memory
  typedef struct packed {
    logic signed [15:0] cur;
    logic signed [15:0] tgt;
    logic [15:0]        step;
    logic [15:0]        lim;
    logic signed [15:0] min_a;
    logic signed [15:0] max_a;
    logic [15:0]        center;
    logic [15:0]        gain;
    logic               inv;
  } msl_rec_t;

  // request to the pulse unit
  typedef struct packed {
    logic               valid;
    logic signed [15:0] pos;
    logic signed [15:0] trim;
    logic [15:0]        gain;
    logic [15:0]        center;
    logic               inv;
  } msl_pulse_req_t;

endpackage
`default_nettype wire

/* hdl/msl_ram.sv */
`default_nettype none
module msl_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 16,
  parameter int unsigned AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hdl/msl_div.sv */
`default_nettype none
module msl_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [15:0]      quot_o
);

  logic [16:0] rem_q, rem_d;
  logic [15:0] dq_q, dq_d;
  logic [15:0] dv_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] rem_sh;
  logic        fit;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q[15:0], dq_q[15]};
    fit    = rem_sh >= {1'b0, dv_q};
    rem_d  = fit ? rem_sh - {1'b0, dv_q} : rem_sh;
    dq_d   = {dq_q[14:0], fit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire

/* hdl/msl_pulse.sv */
`default_nettype none
module msl_pulse import msl_pkg::*; #(
  parameter int unsigned AngleFracBits = AngleFracBitsDef
) (
  input  wire logic           clk_i,
  input  wire msl_pulse_req_t req_i,
  output logic [15:0]         pulse_o
);

  logic signed [16:0] a;
  logic signed [33:0] prod_q;
  logic [15:0]        center_q;
  logic               inv_q;
  logic signed [33:0] off;
  logic signed [34:0] offn;
  logic signed [35:0] sum;

  assign a = 17'(req_i.pos) + 17'(req_i.trim);

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_q   <= 34'(a) * $signed({18'b0, req_i.gain});
      center_q <= req_i.center;
      inv_q    <= req_i.inv;
    end
  end

  // arithmetic shift is the floor division
  always_comb begin
    off  = prod_q >>> AngleFracBits;
    offn = inv_q ? -35'(off) : 35'(off);
    sum  = $signed({20'b0, center_q}) + 36'(offn);
    if (sum < 0) begin
      pulse_o = '0;
    end else if (sum > 36'sd65535) begin
      pulse_o = 16'hFFFF;
    end else begin
      pulse_o = sum[15:0];
    end
  end

endmodule
`default_nettype wire

/* hdl/multi_servo_slew_limiter.sv */
// Servo table with slew-limited positions and pulse widths.
// Input channel: in_valid_i/in_stall_o carry one operation word (command,
// tick, set trim, set enable, calibrate). Output channel: out_valid_o /
// out_stall_i carry one result word per driven or released channel, last_o
// marking the final word of an operation. Of the word-less ops, calibrate and
// single trim finish in idle, trim-all sweeps in its own state, and a command
// passes the read and update states, then waits for the divider if its
// duration is nonzero. With torque on, a tick walks channels 0..n-1 in the
// scan state, each enabled channel through the memory read, update and pulse
// multiply, and output load states; enable-all walks every channel. The channel
// memory has one read and one write port, which sets the per-channel cost.
// A trim-all write sweeps the trim memory one entry per cycle.
// One operation is worked on at a time; in_stall_o is high while busy.
// A stalled output word is held in its register and the walk waits.
// Reset clears enables, trims (by valid bits), torque and sets the channel
// count to 32; per-channel calibration is undefined until calibrated.
`default_nettype none
module multi_servo_slew_limiter import msl_pkg::*; #(
  parameter int unsigned NUM_CHANNELS    = NumChannelsDef,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [5:0]         cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         op_i,
  input  wire logic [4:0]         channel_i,
  input  wire logic               all_channels_i,
  input  wire logic signed [15:0] angle_i,
  input  wire logic [15:0]        duration_ticks_i,
  input  wire logic               enable_i,
  input  wire logic signed [15:0] min_angle_i,
  input  wire logic signed [15:0] max_angle_i,
  input  wire logic [15:0]        center_pulse_i,
  input  wire logic [15:0]        gain_i,
  input  wire logic               invert_i,
  input  wire logic [15:0]        max_step_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [4:0]              out_channel_o,
  output logic [15:0]             pulse_o,
  output logic signed [15:0]      position_o,
  output logic                    last_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned Cap  = (NUM_CHANNELS < MaxOut) ? NUM_CHANNELS : MaxOut;
  localparam int unsigned RecW = $bits(msl_rec_t);

  typedef enum logic [2:0] {
    OP_CMD  = 3'd0,
    OP_TICK = 3'd1,
    OP_TRIM = 3'd2,
    OP_EN   = 3'd3,
    OP_CAL  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RD, S_DAT, S_DIV, S_OUT, S_TRIM
  } state_e;

  function automatic logic signed [15:0] clamp(input logic signed [17:0] v,
                                               input logic signed [15:0] lo,
                                               input logic signed [15:0] hi);
    logic signed [15:0] r;
    if (v < 18'(lo)) begin
      r = lo;
    end else if (v > 18'(hi)) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  state_e state_q;
  op_e    op_q;
  logic   all_q, en_q, torque_q, last_q, rel_q;
  logic signed [15:0] angle_q, pos_q;
  logic [15:0] dur_q;
  logic [5:0]  cnt_q, cfg_q, n_w;
  logic [NUM_CHANNELS-1:0] chen_q, tvld_q, above;
  logic        tv_q, out_valid_q;
  logic [4:0]  out_ch_q;
  logic [15:0] out_pulse_q;
  logic signed [15:0] out_pos_q;
  logic        out_last_q;

  logic [IdxW-1:0] idx, ch_idx;
  logic [5:0]      ch_ext;
  logic            accept, ch_ok, out_free;
  op_e             op_in;

  msl_rec_t  rec, wrec;
  logic [RecW-1:0] rd_raw;
  logic      mwe, mre;
  logic [IdxW-1:0] mwaddr;
  logic      twe;
  logic [IdxW-1:0] twaddr;
  logic [15:0] trd_raw, trim_rd;

  logic        div_start, div_done;
  logic [15:0] quot, dist_abs, stp;
  logic signed [15:0] tclamp, cal_pos, tick_pos;
  logic signed [16:0] diff, dtgt;
  logic signed [17:0] err, s_pos;
  msl_pulse_req_t preq;
  logic [15:0] pulse_w;
  logic        last_w;

  assign ch_ext   = {1'b0, channel_i};
  assign ch_idx   = ch_ext[IdxW-1:0];
  assign idx      = cnt_q[IdxW-1:0];
  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign op_in    = op_e'(op_i);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cfg_q == 6'd0) begin
      n_w = 6'd1;
    end else if (32'(cfg_q) > Cap) begin
      n_w = 6'(Cap);
    end else begin
      n_w = cfg_q;
    end
  end
  assign ch_ok = ch_ext < n_w;

  assign rec     = msl_rec_t'(rd_raw);
  assign trim_rd = tv_q ? trd_raw : 16'd0;

  // command step and tick step
  assign tclamp   = clamp(18'(angle_q), rec.min_a, rec.max_a);
  assign dtgt     = 17'(tclamp) - 17'(rec.cur);
  assign dist_abs = dtgt[16] ? 16'(-dtgt) : dtgt[15:0];
  assign diff     = 17'(rec.tgt) - 17'(rec.cur);
  always_comb begin
    if (18'(diff) > $signed({2'b0, rec.step})) begin
      err = $signed({2'b0, rec.step});
    end else if (18'(diff) < -$signed({2'b0, rec.step})) begin
      err = -$signed({2'b0, rec.step});
    end else begin
      err = 18'(diff);
    end
  end
  assign s_pos    = 18'(rec.cur) + err;
  assign tick_pos = clamp(s_pos, rec.min_a, rec.max_a);
  assign cal_pos  = clamp(18'sd0, min_angle_i, max_angle_i);

  always_comb begin
    stp = (quot < rec.lim) ? quot : rec.lim;
    if (stp == 16'd0) begin
      stp = 16'd1;
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      above[j] = (j > int'(cnt_q)) && (j < int'(n_w));
    end
    if (op_q == OP_TICK) begin
      last_w = ~|(chen_q & above);
    end else begin
      last_w = !all_q || (cnt_q == n_w - 6'd1);
    end
  end

  // memory write and pulse request sources
  always_comb begin
    mwe        = 1'b0;
    mwaddr     = idx;
    wrec       = rec;
    div_start  = 1'b0;
    preq       = '0;
    preq.trim  = trim_rd;
    preq.gain  = rec.gain;
    preq.center = rec.center;
    preq.inv   = rec.inv;
    preq.pos   = tick_pos;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op_in == OP_CAL && ch_ok && min_angle_i < max_angle_i) begin
          mwe         = 1'b1;
          mwaddr      = ch_idx;
          wrec.cur    = cal_pos;
          wrec.tgt    = cal_pos;
          wrec.step   = (max_step_i == 16'd0) ? 16'd1 : max_step_i;
          wrec.lim    = (max_step_i == 16'd0) ? 16'd1 : max_step_i;
          wrec.min_a  = min_angle_i;
          wrec.max_a  = max_angle_i;
          wrec.center = center_pulse_i;
          wrec.gain   = gain_i;
          wrec.inv    = invert_i;
        end
      end
      S_DAT: begin
        priority case (op_q)
          OP_CMD: begin
            if (dur_q == 16'd0) begin
              mwe       = 1'b1;
              wrec.tgt  = tclamp;
              wrec.step = (rec.lim == 16'd0) ? 16'd1 : rec.lim;
            end else begin
              div_start = 1'b1;
            end
          end
          OP_TICK: begin
            mwe        = 1'b1;
            wrec.cur   = tick_pos;
            preq.valid = 1'b1;
          end
          OP_EN: begin
            if (en_q) begin
              mwe        = 1'b1;
              wrec.tgt   = rec.cur;
              wrec.cur   = clamp(18'(rec.cur), rec.min_a, rec.max_a);
              preq.pos   = wrec.cur;
              preq.valid = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          mwe       = 1'b1;
          wrec.tgt  = tclamp;
          wrec.step = stp;
        end
      end
      default: begin
      end
    endcase
  end

  assign mre    = (state_q == S_RD);
  assign twe    = (state_q == S_TRIM) ||
                  (state_q == S_IDLE && accept && op_in == OP_TRIM && !all_channels_i && ch_ok);
  assign twaddr = (state_q == S_TRIM) ? idx : ch_idx;

  msl_ram #(.Depth(NUM_CHANNELS), .Width(RecW), .AddrW(IdxW)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mwe),
    .waddr_i (mwaddr),
    .wdata_i (RecW'(wrec)),
    .re_i    (mre),
    .raddr_i (idx),
    .rdata_o (rd_raw)
  );

  msl_ram #(.Depth(NUM_CHANNELS), .Width(16), .AddrW(IdxW)) u_trim_ram (
    .clk_i   (clk_i),
    .we_i    (twe),
    .waddr_i (twaddr),
    .wdata_i ((state_q == S_TRIM) ? angle_q : angle_i),
    .re_i    (mre),
    .raddr_i (idx),
    .rdata_o (trd_raw)
  );

  msl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dist_abs),
    .divisor_i  (dur_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  msl_pulse #(.AngleFracBits(ANGLE_FRAC_BITS)) u_pulse (
    .clk_i   (clk_i),
    .req_i   (preq),
    .pulse_o (pulse_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= 6'd32;
      torque_q    <= 1'b0;
      chen_q      <= '0;
      tvld_q      <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_CMD;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      if (twe) begin
        tvld_q[twaddr] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q <= op_in;
            unique case (op_in)
              OP_CMD: begin
                cnt_q <= ch_ext;
                if (ch_ok) state_q <= S_RD;
              end
              OP_TICK: begin
                cnt_q <= '0;
                if (torque_q) state_q <= S_SCAN;
              end
              OP_TRIM: begin
                cnt_q <= '0;
                if (all_channels_i) state_q <= S_TRIM;
              end
              OP_EN: begin
                if (all_channels_i) begin
                  torque_q <= enable_i;
                  cnt_q    <= '0;
                  state_q  <= S_SCAN;
                end else begin
                  cnt_q <= ch_ext;
                  if (ch_ok) state_q <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cnt_q >= n_w) begin
            state_q <= S_IDLE;
          end else if (op_q == OP_EN || chen_q[idx]) begin
            state_q <= S_RD;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_RD: begin
          state_q <= S_DAT;
        end
        S_DAT: begin
          if (op_q == OP_CMD) begin
            state_q <= (dur_q == 16'd0) ? S_IDLE : S_DIV;
          end else begin
            if (op_q == OP_EN) chen_q[idx] <= en_q;
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_IDLE;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (op_q == OP_TICK || all_q) begin
              cnt_q   <= cnt_q + 6'd1;
              state_q <= S_SCAN;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_TRIM: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == n_w - 6'd1) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // word payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      all_q   <= all_channels_i;
      angle_q <= angle_i;
      dur_q   <= duration_ticks_i;
      en_q    <= enable_i;
    end
    if (mre) begin
      tv_q <= tvld_q[idx];
    end
    if (state_q == S_DAT) begin
      last_q <= last_w;
      rel_q  <= (op_q == OP_EN) && !en_q;
      pos_q  <= (op_q == OP_EN && !en_q) ? rec.cur :
                ((op_q == OP_TICK) ? tick_pos : preq.pos);
    end
    if (state_q == S_OUT && out_free) begin
      out_ch_q    <= cnt_q[4:0];
      out_pulse_q <= rel_q ? 16'd0 : pulse_w;
      out_pos_q   <= pos_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign pulse_o       = out_pulse_q;
  assign position_o    = out_pos_q;
  assign last_o        = out_last_q;

`ifndef NO_ASSERTIONS
  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished outside wait");
  a_trim_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TRIM |-> cnt_q < n_w) else $error("trim sweep past table");
  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> cnt_q < n_w) else $error("read of channel past table");
`endif

endmodule
`default_nettype wire

/* dv/tb_multi_servo_slew_limiter.sv */
`default_nettype none
module tb_multi_servo_slew_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    OP_COMMAND = 3'd0,
    OP_TICK    = 3'd1,
    OP_TRIM    = 3'd2,
    OP_ENABLE  = 3'd3,
    OP_CAL     = 3'd4
  } servo_op_e;

  typedef struct {
    logic [2:0]         op;
    logic [4:0]         ch;
    logic               all;
    logic signed [15:0] angle;
    logic [15:0]        dur;
    logic               en;
    logic signed [15:0] min_a;
    logic signed [15:0] max_a;
    logic [15:0]        center;
    logic [15:0]        gain;
    logic               inv;
    logic [15:0]        max_step;
  } servo_word_t;

  typedef struct {
    logic [4:0]         ch;
    logic [15:0]        pulse;
    logic signed [15:0] pos;
    logic               last;
  } pulse_word_t;

  class servo_scoreboard;
    pulse_word_t pending[$];
    int errors;
    int unsigned chan_count = 32;
    int cur[32], tgt[32], step[32], lim[32], trim[32], lo[32], hi[32];
    int unsigned center[32], gain[32];
    bit inv[32], en[32];
    bit torque;

    function void report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    function void add_word(pulse_word_t w);
      pending.insert(pending.size(), w);
    endfunction

    function int clamp(int v, int l, int h);
      return v < l ? l : (v > h ? h : v);
    endfunction

    function int unsigned table_n();
      return chan_count < 1 ? 1 : (chan_count > 32 ? 32 : chan_count);
    endfunction

    function logic [15:0] pulse_of(int c, int p);
      longint prod, q;
      prod = longint'(p + trim[c]) * longint'(gain[c]);
      q = prod >>> 12;
      if (inv[c]) q = -q;
      q = q + longint'(center[c]);
      return q < 0 ? 16'd0 : (q > 65535 ? 16'hffff : 16'(q));
    endfunction

    function void drive(int c, int a);
      pulse_word_t w;
      cur[c] = clamp(a, lo[c], hi[c]);
      w.ch = 5'(c); w.pulse = pulse_of(c, cur[c]); w.pos = 16'(cur[c]); w.last = 1'b0;
      add_word(w);
    endfunction

    function void resume_or_release(int c, bit e);
      pulse_word_t w;
      en[c] = e;
      if (e) begin
        tgt[c] = cur[c];
        drive(c, cur[c]);
      end else begin
        w.ch = 5'(c); w.pulse = 16'd0; w.pos = 16'(cur[c]); w.last = 1'b0;
        add_word(w);
      end
    endfunction

    function void note_input(servo_word_t w);
      int unsigned n, size_prior, gap, s;
      int c, t, e;
      n = table_n();
      size_prior = pending.size();
      c = w.ch;
      case (w.op)
        OP_COMMAND: if (c < n) begin
          t = clamp(w.angle, lo[c], hi[c]);
          gap = (t > cur[c]) ? t - cur[c] : cur[c] - t;
          s = lim[c];
          tgt[c] = t;
          if (w.dur != 0 && gap / w.dur < s) s = gap / w.dur;
          step[c] = s < 1 ? 1 : s;
        end
        OP_TICK: if (torque) begin
          for (int i = 0; i < n; i++)
            if (en[i]) begin
              e = clamp(tgt[i] - cur[i], -step[i], step[i]);
              drive(i, cur[i] + e);
            end
        end
        OP_TRIM: begin
          if (w.all) for (int i = 0; i < n; i++) trim[i] = w.angle;
          else if (c < n) trim[c] = w.angle;
        end
        OP_ENABLE: begin
          if (w.all) begin
            torque = w.en;
            for (int i = 0; i < n; i++) resume_or_release(i, w.en);
          end else if (c < n) resume_or_release(c, w.en);
        end
        OP_CAL: if (c < n && w.min_a < w.max_a) begin
          lo[c] = w.min_a; hi[c] = w.max_a;
          center[c] = w.center; gain[c] = w.gain; inv[c] = w.inv;
          lim[c] = w.max_step < 1 ? 1 : w.max_step;
          step[c] = lim[c];
          cur[c] = clamp(0, lo[c], hi[c]);
          tgt[c] = cur[c];
        end
        default: ;
      endcase
      if (pending.size() > size_prior) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(pulse_word_t got);
      pulse_word_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word ch %0d", got.ch));
        return;
      end
      exp = pending.pop_front();
      if (got.ch !== exp.ch || got.pulse !== exp.pulse || got.pos !== exp.pos ||
          got.last !== exp.last)
        report($sformatf("got ch %0d pulse %0d pos %0d last %0d, want %0d %0d %0d %0d",
               got.ch, got.pulse, got.pos, got.last,
               exp.ch, exp.pulse, exp.pos, exp.last));
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i, in_valid_i, in_stall_o, all_channels_i, enable_i;
  logic invert_i, out_valid_o, out_stall_i, last_o;
  logic [5:0] cfg_wdata_i;
  logic [2:0] op_i;
  logic [4:0] channel_i, out_channel_o;
  logic signed [15:0] angle_i, min_angle_i, max_angle_i, position_o;
  logic [15:0] duration_ticks_i, center_pulse_i, gain_i, max_step_i, pulse_o;

  servo_scoreboard sb = new();
  bit quiet, hold_req;

  multi_servo_slew_limiter dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o, .op_i,
    .channel_i, .all_channels_i, .angle_i, .duration_ticks_i, .enable_i,
    .min_angle_i, .max_angle_i, .center_pulse_i, .gain_i, .invert_i, .max_step_i,
    .out_valid_o, .out_stall_i, .out_channel_o, .pulse_o, .position_o, .last_o
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb_multi_servo_slew_limiter: errors");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 0;
      end else begin
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    pulse_word_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ch = out_channel_o; got.pulse = pulse_o; got.pos = position_o; got.last = last_o;
      sb.check_result(got);
    end
  end

  task automatic send(servo_word_t w);
    op_i <= w.op; channel_i <= w.ch; all_channels_i <= w.all; angle_i <= w.angle;
    duration_ticks_i <= w.dur; enable_i <= w.en; min_angle_i <= w.min_a;
    max_angle_i <= w.max_a; center_pulse_i <= w.center; gain_i <= w.gain;
    invert_i <= w.inv; max_step_i <= w.max_step;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic set_channels(logic [5:0] v);
    wait_idle();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.chan_count = 32'(v);
  endtask

  function automatic servo_word_t random_word(servo_op_e op);
    servo_word_t w;
    int unsigned n;
    n = sb.table_n();
    w.op = op;
    w.ch = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
    w.all = $urandom_range(0, 4) == 0;
    w.angle = $urandom_range(0, 1) ? 16'($urandom) : 16'($signed($urandom_range(0, 8000)) - 4000);
    w.dur = $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
    w.en = $urandom_range(0, 3) != 0;
    w.min_a = 16'($urandom);
    w.max_a = 16'($urandom);
    // mostly well-formed limits
    if ($urandom_range(0, 7) != 0 && w.min_a > w.max_a) begin
      w.min_a = w.max_a;
      w.max_a = 16'($urandom);
      if (w.min_a > w.max_a) w.min_a = -w.min_a - 1;
    end
    w.center = 16'($urandom);
    w.gain = 16'($urandom);
    w.inv = 1'($urandom);
    w.max_step = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 600));
    return w;
  endfunction

  task automatic random_phase(int count);
    int r;
    servo_word_t w;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 28) w = random_word(OP_COMMAND);
      else if (r < 55) w = random_word(OP_TICK);
      else if (r < 63) w = random_word(OP_TRIM);
      else if (r < 78) begin
        w = random_word(OP_ENABLE);
        if (!sb.torque) begin w.all = 1; w.en = 1; end
      end else if (r < 93) w = random_word(OP_CAL);
      else begin
        w = random_word(OP_TICK);
        w.op = 3'($urandom_range(5, 7));
      end
      send(w);
    end
  endtask

  initial begin
    servo_word_t w;
    rst_ni = 0; cfg_we_i = 0; cfg_wdata_i = '0; in_valid_i = 0; op_i = '0;
    channel_i = '0; all_channels_i = 0; angle_i = '0; duration_ticks_i = '0;
    enable_i = 0; min_angle_i = '0; max_angle_i = '0; center_pulse_i = '0;
    gain_i = '0; invert_i = 0; max_step_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // every channel gets limits before anything reads its entry
    for (int c = 0; c < 32; c++) begin
      w = random_word(OP_CAL);
      w.ch = 5'(c);
      if (w.min_a >= w.max_a) begin w.min_a = -100; w.max_a = 100; end
      if (c == 0) begin
        w.min_a = 16'sh8000; w.max_a = 16'sh7fff; w.gain = 16'hffff;
        w.center = 16'hffff; w.max_step = 0;
      end
      if (c == 1) begin w.min_a = 16'sd10; w.max_a = 16'sd500; w.center = 0; w.inv = 1; end
      if (c == 2) begin w.min_a = -16'sd900; w.max_a = -16'sd20; w.max_step = 16'hffff; end
      send(w);
    end
    // directed corners
    w = random_word(OP_CAL); w.ch = 3; w.min_a = 16'sd50; w.max_a = 16'sd50; send(w);
    w = random_word(OP_TICK); send(w);
    w = random_word(OP_ENABLE); w.all = 1; w.en = 1; send(w);
    w = random_word(OP_COMMAND); w.ch = 0; w.angle = 16'sh7fff; w.dur = 0; send(w);
    w = random_word(OP_COMMAND); w.ch = 1; w.angle = 16'sh8000; w.dur = 16'hffff; send(w);
    w = random_word(OP_COMMAND); w.ch = 2; w.angle = 16'sh7fff; w.dur = 3; send(w);
    w = random_word(OP_TRIM); w.all = 1; w.angle = 16'sh7fff; send(w);
    w = random_word(OP_TICK); send(w);
    w = random_word(OP_TRIM); w.all = 0; w.ch = 0; w.angle = 16'sh8000; send(w);
    w = random_word(OP_TICK); send(w);
    w = random_word(OP_ENABLE); w.all = 0; w.ch = 4; w.en = 0; send(w);
    w = random_word(OP_TICK); w.op = 3'd7; send(w);
    w = random_word(OP_ENABLE); w.all = 1; w.en = 0; send(w);
    w = random_word(OP_TICK); send(w);
    w = random_word(OP_ENABLE); w.all = 1; w.en = 1; send(w);
    w = random_word(OP_TICK); send(w);

    set_channels(6'd1);
    w = random_word(OP_COMMAND); w.ch = 5; send(w);
    w = random_word(OP_ENABLE); w.all = 1; w.en = 1; send(w);
    random_phase(15);

    set_channels(6'd0);
    random_phase(10);

    set_channels(6'd63);
    // long receiver hold-off while ticks keep coming
    hold_req = 1;
    w = random_word(OP_ENABLE); w.all = 1; w.en = 1; send(w);
    for (int k = 0; k < 8; k++) begin
      w = random_word(OP_TICK);
      send(w);
    end
    random_phase(20);

    set_channels(6'd7);
    random_phase(20);

    set_channels(6'd32);
    random_phase(15);
    wait_idle();
    quiet = 1;
    random_phase(10);

    wait_idle();
    if (sb.errors == 0)
      $display("tb_multi_servo_slew_limiter: clean");
    else
      $display("tb_multi_servo_slew_limiter: errors");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hdl/msl_pkg.sv
hdl/msl_ram.sv
hdl/msl_div.sv
hdl/msl_pulse.sv
hdl/multi_servo_slew_limiter.sv
dv/tb_multi_servo_slew_limiter.sv
